// ===== rtl/hash_conflict_dependency_tracker_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the hash conflict dependency tracker
// Concurrent checks that fold away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef HASH_CONFLICT_DEPENDENCY_TRACKER_DEFINES_SVH
`define HASH_CONFLICT_DEPENDENCY_TRACKER_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define HCDT_ASSERT_IMP(lbl, ck, rst_n, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("hcdt: implication check failed");
// next-cycle implication
`define HCDT_ASSERT_NXT(lbl, ck, rst_n, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("hcdt: next-cycle check failed");
`else
`define HCDT_ASSERT_IMP(lbl, ck, rst_n, ante, cons)
`define HCDT_ASSERT_NXT(lbl, ck, rst_n, ante, cons)
`endif

`endif

// ===== rtl/hcdt_pkg.sv =====
// ----------------------------------------------------------------------------
// hcdt_pkg
// Shared constants and chain control types of the dependency tracker.
// ----------------------------------------------------------------------------
package hcdt_pkg;

	localparam int ACCT_W   = 64;
	localparam int OUT_ID_W = 32;

	// command from the controller to the predecessor chain
	typedef struct packed {
		logic ins;    // offer a predecessor id for sorted insertion
		logic shift;  // pop the head, every cell takes its right neighbour
	} hcdt_chain_cmd_t;

	// status from the chain back to the controller
	typedef struct packed {
		logic head_vld;  // at least one id held
		logic next_vld;  // a second id held behind the head
		logic full;      // last cell occupied
		logic dup;       // offered id already held
	} hcdt_chain_st_t;

endpackage

// ===== rtl/hcdt_cell.sv =====
// ----------------------------------------------------------------------------
// hcdt_cell
// One cell of the sorted predecessor chain: holds one id and a valid bit.
// ----------------------------------------------------------------------------
module hcdt_cell import hcdt_pkg::*; #(
	parameter int W = 32
) (
	input  logic            clk,
	input  logic            arst_n,
	input  hcdt_chain_cmd_t cmd,
	input  logic [W-1:0]    new_val,
	input  logic            left_lt,
	input  logic            left_vld,
	input  logic [W-1:0]    left_val,
	input  logic            right_vld,
	input  logic [W-1:0]    right_val,
	output logic            vld,
	output logic [W-1:0]    val,
	output logic            lt,
	output logic            eq
);

	logic         vld_q;
	logic [W-1:0] val_q;

	assign vld = vld_q;
	assign val = val_q;
	assign lt  = vld_q && (val_q < new_val);
	assign eq  = vld_q && (val_q == new_val);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (cmd.shift) begin
			vld_q <= right_vld;
		end else if (cmd.ins && !lt) begin
			// new id lands here or pushes the left neighbour in
			vld_q <= left_lt ? 1'b1 : left_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.shift) begin
			val_q <= right_val;
		end else if (cmd.ins && !lt) begin
			val_q <= left_lt ? new_val : left_val;
		end
	end

endmodule

// ===== rtl/hcdt_chain.sv =====
// ----------------------------------------------------------------------------
// hcdt_chain
// Row of cells keeping distinct predecessor ids in ascending order.
// ----------------------------------------------------------------------------
module hcdt_chain import hcdt_pkg::*; #(
	parameter int W     = 32,
	parameter int DEPTH = 16
) (
	input  logic            clk,
	input  logic            arst_n,
	input  hcdt_chain_cmd_t cmd,
	input  logic [W-1:0]    new_val,
	output hcdt_chain_st_t  st,
	output logic [W-1:0]    head_val
);

	logic [DEPTH-1:0] vld;
	logic [DEPTH-1:0] lt;
	logic [DEPTH-1:0] eq;
	logic [W-1:0]     val [DEPTH];
	hcdt_chain_cmd_t  cell_cmd;

	// drop duplicates and anything offered to a full row
	assign cell_cmd.shift = cmd.shift;
	assign cell_cmd.ins   = cmd.ins && !(|eq) && !vld[DEPTH-1];

	assign st.head_vld = vld[0];
	assign st.next_vld = vld[1];
	assign st.full     = vld[DEPTH-1];
	assign st.dup      = |eq;
	assign head_val    = val[0];

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic         l_lt;
		logic         l_vld;
		logic [W-1:0] l_val;
		logic         r_vld;
		logic [W-1:0] r_val;

		if (i == 0) begin : g_first
			assign l_lt  = 1'b1;
			assign l_vld = 1'b0;
			assign l_val = '0;
		end else begin : g_mid
			assign l_lt  = lt[i-1];
			assign l_vld = vld[i-1];
			assign l_val = val[i-1];
		end

		if (i == DEPTH - 1) begin : g_last
			assign r_vld = 1'b0;
			assign r_val = '0;
		end else begin : g_inner
			assign r_vld = vld[i+1];
			assign r_val = val[i+1];
		end

		hcdt_cell #(
			.W (W)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.cmd       (cell_cmd),
			.new_val   (new_val),
			.left_lt   (l_lt),
			.left_vld  (l_vld),
			.left_val  (l_val),
			.right_vld (r_vld),
			.right_val (r_val),
			.vld       (vld[i]),
			.val       (val[i]),
			.lt        (lt[i]),
			.eq        (eq[i])
		);
	end

endmodule

// ===== rtl/hash_conflict_dependency_tracker.sv =====
// ----------------------------------------------------------------------------
// hash_conflict_dependency_tracker
// Builds dependency links between transactions that share a table slot.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready): one account reference per request.
// Output channel (out_valid/out_ready): one link record per held predecessor,
// or one root record, per transaction. A reference takes two steps: accept
// and slot read, then compare, slot write-back and sorted insertion into the
// predecessor chain; the slot table's registered read-modify-write sets them.
// On the last reference of a transaction the chain is popped at its head, one
// result per cycle while out_ready is high; the next request is taken only
// after the last result of the transaction has been loaded.
// The output register is separate from the intake, so further references are
// taken while a result waits; a stalled receiver holds the chain unpopped.
// After reset the slot table is cleared one entry a cycle, up to the last
// entry, with in_ready low. TABLE_SLOTS must be a power of two;
// the account's low bits select the slot.
// ----------------------------------------------------------------------------
`include "hash_conflict_dependency_tracker_defines.svh"

module hash_conflict_dependency_tracker import hcdt_pkg::*; #(
	parameter int TABLE_SLOTS = 4096,
	parameter int MAX_PREDS   = 16,
	parameter int ID_WIDTH    = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [ID_WIDTH-1:0] txn_id,
	input  logic [ACCT_W-1:0]   account_id,
	input  logic                has_account,
	input  logic                last_ref,
	output logic                out_valid,
	input  logic                out_ready,
	output logic                is_root,
	output logic [OUT_ID_W-1:0] prev_txn,
	output logic [OUT_ID_W-1:0] this_txn,
	output logic                last_result,
	output logic                overflow
);

	localparam int SLOT_W = $clog2(TABLE_SLOTS);

	localparam logic [1:0] ST_CLEAR = 2'd0;
	localparam logic [1:0] ST_IDLE  = 2'd1;
	localparam logic [1:0] ST_LOOK  = 2'd2;
	localparam logic [1:0] ST_EMIT  = 2'd3;

	logic [1:0]          state_q;
	logic [SLOT_W-1:0]   clr_idx_q;
	logic                ovf_q;

	logic [ID_WIDTH-1:0] txn_s1;
	logic [SLOT_W-1:0]   slot_s1;
	logic                has_s1;
	logic                last_s1;

	// slot table: valid bit on top of the id
	logic [ID_WIDTH:0]   mem [TABLE_SLOTS];
	logic [ID_WIDTH:0]   rd_q;
	logic                mem_we;
	logic [SLOT_W-1:0]   mem_waddr;
	logic [ID_WIDTH:0]   mem_wdata;

	logic                accept;
	logic                hit;
	logic                out_load;
	logic                emit_last;

	hcdt_chain_cmd_t     chain_cmd;
	hcdt_chain_st_t      chain_st;
	logic [ID_WIDTH-1:0] head_val;

	logic                out_vld_q;
	logic                is_root_q;
	logic [OUT_ID_W-1:0] prev_q;
	logic [OUT_ID_W-1:0] this_q;
	logic                last_q;
	logic                ovf_out_q;

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;

	assign hit = (state_q == ST_LOOK) && has_s1 && rd_q[ID_WIDTH]
		&& (rd_q[ID_WIDTH-1:0] != txn_s1);

	assign out_load  = (state_q == ST_EMIT) && (!out_vld_q || out_ready);
	assign emit_last = !chain_st.head_vld || !chain_st.next_vld;

	assign chain_cmd.ins   = hit;
	assign chain_cmd.shift = out_load && chain_st.head_vld;

	assign mem_we    = (state_q == ST_CLEAR) || ((state_q == ST_LOOK) && has_s1);
	assign mem_waddr = (state_q == ST_CLEAR) ? clr_idx_q : slot_s1;
	assign mem_wdata = (state_q == ST_CLEAR) ? '0 : {1'b1, txn_s1};

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		rd_q <= mem[account_id[SLOT_W-1:0]];
	end

	hcdt_chain #(
		.W     (ID_WIDTH),
		.DEPTH (MAX_PREDS)
	) u_chain (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (chain_cmd),
		.new_val  (rd_q[ID_WIDTH-1:0]),
		.st       (chain_st),
		.head_val (head_val)
	);

	always_ff @(posedge clk) begin
		if (accept) begin
			txn_s1  <= txn_id;
			slot_s1 <= account_id[SLOT_W-1:0];
			has_s1  <= has_account;
			last_s1 <= last_ref;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLEAR;
			clr_idx_q <= '0;
			ovf_q     <= 1'b0;
		end else begin
			unique case (state_q)
				ST_CLEAR: begin
					clr_idx_q <= clr_idx_q + 1'b1;
					if (clr_idx_q == SLOT_W'(TABLE_SLOTS - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_LOOK;
					end
				end
				ST_LOOK: begin
					// new distinct id with no room left: drop it
					if (hit && !chain_st.dup && chain_st.full) begin
						ovf_q <= 1'b1;
					end
					state_q <= last_s1 ? ST_EMIT : ST_IDLE;
				end
				ST_EMIT: begin
					if (out_load && emit_last) begin
						ovf_q   <= 1'b0;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (out_load) begin
			out_vld_q <= 1'b1;
		end else if (out_ready) begin
			out_vld_q <= 1'b0;
		end
	end

	// hold the transaction id with the result, intake may move on
	always_ff @(posedge clk) begin
		if (out_load) begin
			is_root_q <= !chain_st.head_vld;
			prev_q    <= chain_st.head_vld ? OUT_ID_W'(head_val) : '0;
			this_q    <= OUT_ID_W'(txn_s1);
			last_q    <= emit_last;
			ovf_out_q <= chain_st.head_vld && ovf_q;
		end
	end

	assign out_valid   = out_vld_q;
	assign is_root     = is_root_q;
	assign prev_txn    = prev_q;
	assign this_txn    = this_q;
	assign last_result = last_q;
	assign overflow    = ovf_out_q;

	`HCDT_ASSERT_IMP(a_no_accept_in_clear, clk, arst_n, state_q == ST_CLEAR, !in_ready)
	`HCDT_ASSERT_NXT(a_look_no_last_idle, clk, arst_n, (state_q == ST_LOOK) && !last_s1, state_q == ST_IDLE)
	`HCDT_ASSERT_IMP(a_root_is_final, clk, arst_n, out_valid && is_root, last_result && !overflow)
	`HCDT_ASSERT_NXT(a_emit_done_empty, clk, arst_n, out_load && emit_last, !chain_st.head_vld && !ovf_q)

endmodule
